/* hdl/fdpc_pkg.sv */
// Shared types and constants of the fluid density position correction unit.
`default_nettype none
package fdpc_pkg;

  localparam int STIFF_BITS = 16;
  localparam int MAG_W      = 62;
  localparam int ACC_W      = 63;
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 2;

  localparam logic [MAG_W-1:0] MAG_LIMIT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_COEFF,
    REG_INV_RHO,
    REG_STIFF
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_W,
    MUL_G,
    MUL_T,
    MUL_P,
    MUL_Q
  } mul_op_t;

  typedef struct packed {
    logic       ready;
    logic       take;
    logic       begin_grp;
    logic       diff;
    logic       sq;
    logic       root_start;
    logic       dd;
    logic       mul_start;
    mul_op_t    mul_op;
    logic       div_start;
    logic       acc;
    logic       sat;
    logic       out_load;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op;
    logic last;
    logic skip;
    logic root_done;
    logic mul_done;
    logic div_done;
    logic out_full;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/fdpc_in_if.sv */
// Request channel carrying particle and neighbour data.
`default_nettype none
interface fdpc_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [15:0]        particle_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] lambda;
  logic               last;

  modport source (output valid, op, particle_index, pos_x, pos_y, pos_z, lambda, last,
                  input ready);
  modport sink (input valid, op, particle_index, pos_x, pos_y, pos_z, lambda, last,
                output ready);
endinterface
`default_nettype wire

/* hdl/fdpc_out_if.sv */
// Result channel carrying the position correction of one particle.
`default_nettype none
interface fdpc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        result_index;
  logic signed [31:0] delta_x;
  logic signed [31:0] delta_y;
  logic signed [31:0] delta_z;
  logic               saturated;

  modport source (output valid, result_index, delta_x, delta_y, delta_z, saturated,
                  input ready);
  modport sink (input valid, result_index, delta_x, delta_y, delta_z, saturated,
                output ready);
endinterface
`default_nettype wire

/* hdl/fluid_density_position_correction_unit.sv */
// Top level of the fluid density position correction unit.
//
//  channel  | dir | transfer                 | payload
//  in_ch    | in  | valid && ready           | op, particle_index, pos_x/y/z, lambda, last
//  out_ch   | out | valid && ready           | result_index, delta_x/y/z, saturated
//  cfg      | in  | cfg_we                   | cfg_index, cfg_data
//
// A skipped neighbour ends after the range check; one in range passes through the shared
// divider (31+FRAC_BITS steps per component), the 32-step square root and the multiplier.
// A last request then scales the three sums and waits while a result is still pending.
// Reset is synchronous; it restores the register defaults and clears the sums.
// A pending result sits in the output register while the next request is taken.
`default_nettype none
module fluid_density_position_correction_unit import fdpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  fdpc_in_if.sink              in_ch,
  fdpc_out_if.source           out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fdpc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  fdpc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

/* hdl/fdpc_mul.sv */
// Sequential 64x64 multiplier, 16 bits a cycle, with one of two fixed shifts and clipping.
`default_nettype none
module fdpc_mul import fdpc_pkg::*; #(
  parameter int SHIFT_LONG  = 16,
  parameter int SHIFT_SHORT = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             short_shift,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic             done,
  output logic [MAG_W-1:0] value,
  output logic             clip
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic         short_r;
  logic [79:0]  prod;
  logic [127:0] shifted;

  assign prod    = 80'(a_r) * 80'(b_r[63:48]);
  assign shifted = short_r ? (acc >> SHIFT_SHORT) : (acc >> SHIFT_LONG);
  assign clip    = |shifted[127:MAG_W];
  assign value   = clip ? MAG_LIMIT : shifted[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r     <= a;
        b_r     <= b;
        acc     <= '0;
        cnt     <= '0;
        busy    <= 1'b1;
        short_r <= short_shift;
      end else if (busy) begin
        acc <= {acc[111:0], 16'b0} + {48'b0, prod};
        b_r <= {b_r[47:0], 16'b0};
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/fdpc_dp.sv */
// Datapath: registers, square root, divider, multiplier and accumulators.
`default_nettype none
module fdpc_dp import fdpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  fdpc_in_if.sink              in_ch,
  fdpc_out_if.source           out_ch,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);

  localparam int NW  = 31 + FRAC_BITS;
  localparam int DCW = $clog2(NW);
  localparam logic signed [63:0] ACC_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

  logic [30:0] radius;
  logic [47:0] coeff;
  logic [31:0] ird;
  logic [16:0] stiff;

  logic               in_op;
  logic               in_last;
  logic [15:0]        in_idx;
  logic signed [31:0] in_pos [3];
  logic signed [31:0] in_lam;

  logic signed [31:0] own_pos [3];
  logic signed [31:0] own_lam;
  logic [15:0]        held_idx;
  logic signed [ACC_W-1:0] acc [3];
  logic               clip;

  logic [31:0] ar [3];
  logic [2:0]  rneg;
  logic        far;
  logic [61:0] hh;
  logic        lam_neg;
  logic [32:0] lmag;
  logic [63:0] sumsq;

  logic [63:0] sq_val;
  logic [34:0] sq_rem;
  logic [31:0] sq_root;
  logic [4:0]  sq_cnt;
  logic        sq_busy;
  logic        root_done;
  logic [30:0] len;

  logic [61:0] dd;

  logic [NW-1:0]  dv_num;
  logic [31:0]    dv_rem;
  logic [NW-1:0]  dv_q;
  logic [DCW-1:0] dv_cnt;
  logic           dv_busy;
  logic           div_done;

  logic [MAG_W-1:0] w;
  logic [MAG_W-1:0] g;
  logic [MAG_W-1:0] t;
  logic [MAG_W-1:0] p;
  logic [MAG_W-1:0] q;
  mul_op_t          mul_op_r;

  logic signed [31:0] dlt [3];

  logic               out_full;
  logic [15:0]        out_idx;
  logic signed [31:0] out_d [3];
  logic               out_sat;

  logic signed [32:0] rdiff [3];
  logic [31:0]        rmag [3];
  logic               far_n;
  logic signed [32:0] lam33;
  logic [61:0]        hh_n;
  logic [63:0]        sqp;
  logic [34:0]        sq_rem_n;
  logic [33:0]        sq_trial;
  logic [30:0]        gap;
  logic [61:0]        dd_full;
  logic [31:0]        dv_rem_n;
  logic [MAG_W-1:0]   acc_mag;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic               mul_done;
  logic [MAG_W-1:0]   mul_val;
  logic               mul_clip;
  logic signed [63:0] st;
  logic signed [63:0] asum;
  logic signed [63:0] asum_c;
  logic               acc_clip;
  logic [31:0]        sat_val;
  logic               sat_clip;
  logic [32:0]        q_neg;

  always_comb begin
    far_n = 1'b0;
    for (int c = 0; c < 3; c++) begin
      rdiff[c] = $signed({own_pos[c][31], own_pos[c]}) - $signed({in_pos[c][31], in_pos[c]});
      rmag[c]  = rdiff[c][32] ? 32'(-rdiff[c]) : rdiff[c][31:0];
      if (rmag[c] >= {1'b0, radius}) far_n = 1'b1;
    end
  end

  assign lam33    = $signed({own_lam[31], own_lam}) + $signed({in_lam[31], in_lam});
  assign hh_n     = 62'(radius) * 62'(radius);
  assign sqp      = 64'(ar[cmd.sel]) * 64'(ar[cmd.sel]);
  assign sq_rem_n = {sq_rem[32:0], sq_val[63:62]};
  assign sq_trial = {sq_root, 2'b01};
  assign gap      = radius - len;
  assign dd_full  = 62'(gap) * 62'(gap);
  assign dv_rem_n = {dv_rem[30:0], dv_num[NW-1]};
  assign acc_mag  = acc[cmd.sel][ACC_W-1] ? MAG_W'(-acc[cmd.sel]) : acc[cmd.sel][MAG_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_W: begin
        mul_a = 64'(coeff);
        mul_b = 64'(dd);
      end
      MUL_G: begin
        mul_a = 64'(w);
        mul_b = 64'(dv_q);
      end
      MUL_T: begin
        mul_a = 64'(g);
        mul_b = 64'(lmag);
      end
      MUL_P: begin
        mul_a = 64'(acc_mag);
        mul_b = 64'(ird);
      end
      MUL_Q: begin
        mul_a = 64'(p);
        mul_b = 64'(stiff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fdpc_mul #(
    .SHIFT_LONG  (FRAC_BITS),
    .SHIFT_SHORT (STIFF_BITS)
  ) u_mul (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.mul_start),
    .short_shift (cmd.mul_op == MUL_Q),
    .a           (mul_a),
    .b           (mul_b),
    .done        (mul_done),
    .value       (mul_val),
    .clip        (mul_clip)
  );

  always_comb begin
    st       = (rneg[cmd.sel] == lam_neg) ? -$signed({2'b0, t}) : $signed({2'b0, t});
    asum     = $signed({acc[cmd.sel][ACC_W-1], acc[cmd.sel]}) + st;
    asum_c   = asum;
    acc_clip = 1'b0;
    if (asum > ACC_MAX) begin
      asum_c   = ACC_MAX;
      acc_clip = 1'b1;
    end else if (asum < -ACC_MAX) begin
      asum_c   = -ACC_MAX;
      acc_clip = 1'b1;
    end
  end

  always_comb begin
    sat_clip = 1'b0;
    q_neg    = 33'd0 - 33'(q);
    if (acc[cmd.sel][ACC_W-1]) begin
      if (q > 62'h8000_0000) begin
        sat_val  = 32'h8000_0000;
        sat_clip = 1'b1;
      end else begin
        sat_val = q_neg[31:0];
      end
    end else if (q > 62'h7FFF_FFFF) begin
      sat_val  = 32'h7FFF_FFFF;
      sat_clip = 1'b1;
    end else begin
      sat_val = q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= 31'd6554;
      coeff     <= 48'd65536;
      ird       <= 32'd66;
      stiff     <= 17'd65536;
      own_pos   <= '{default: '0};
      own_lam   <= '0;
      held_idx  <= '0;
      acc       <= '{default: '0};
      clip      <= 1'b0;
      sq_busy   <= 1'b0;
      root_done <= 1'b0;
      dv_busy   <= 1'b0;
      div_done  <= 1'b0;
      out_full  <= 1'b0;
      sq_cnt    <= '0;
      dv_cnt    <= '0;
    end else begin
      root_done <= 1'b0;
      div_done  <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_RADIUS:  radius <= cfg_data[30:0];
          REG_COEFF:   coeff  <= cfg_data[47:0];
          REG_INV_RHO: ird    <= cfg_data[31:0];
          REG_STIFF:   stiff  <= cfg_data[16:0];
          default:     radius <= radius;
        endcase
      end

      if (cmd.take) begin
        in_op     <= in_ch.op;
        in_last   <= in_ch.last;
        in_idx    <= in_ch.particle_index;
        in_pos[0] <= in_ch.pos_x;
        in_pos[1] <= in_ch.pos_y;
        in_pos[2] <= in_ch.pos_z;
        in_lam    <= in_ch.lambda;
      end

      if (cmd.begin_grp) begin
        own_pos  <= in_pos;
        own_lam  <= in_lam;
        held_idx <= in_idx;
        acc      <= '{default: '0};
        clip     <= 1'b0;
      end

      if (cmd.diff) begin
        for (int c = 0; c < 3; c++) begin
          ar[c]   <= rmag[c];
          rneg[c] <= rdiff[c][32];
        end
        far     <= far_n;
        hh      <= hh_n;
        lam_neg <= lam33[32];
        lmag    <= lam33[32] ? 33'(-lam33) : 33'(lam33);
        sumsq   <= '0;
      end

      if (cmd.sq) sumsq <= sumsq + sqp;

      if (cmd.root_start) begin
        sq_val  <= sumsq;
        sq_rem  <= '0;
        sq_root <= '0;
        sq_cnt  <= '0;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        sq_val <= {sq_val[61:0], 2'b00};
        if (sq_rem_n >= {1'b0, sq_trial}) begin
          sq_rem  <= sq_rem_n - {1'b0, sq_trial};
          sq_root <= {sq_root[30:0], 1'b1};
        end else begin
          sq_rem  <= sq_rem_n;
          sq_root <= {sq_root[30:0], 1'b0};
        end
        sq_cnt <= sq_cnt + 5'd1;
        if (sq_cnt == 5'd31) begin
          sq_busy   <= 1'b0;
          root_done <= 1'b1;
        end
      end

      if (root_done) len <= sq_root[30:0];

      if (cmd.dd) dd <= dd_full >> FRAC_BITS;

      if (cmd.div_start) begin
        dv_num  <= {ar[cmd.sel][30:0], FRAC_BITS'(0)};
        dv_rem  <= '0;
        dv_q    <= '0;
        dv_cnt  <= '0;
        dv_busy <= 1'b1;
      end else if (dv_busy) begin
        dv_num <= {dv_num[NW-2:0], 1'b0};
        if (dv_rem_n >= {1'b0, len}) begin
          dv_rem <= dv_rem_n - {1'b0, len};
          dv_q   <= {dv_q[NW-2:0], 1'b1};
        end else begin
          dv_rem <= dv_rem_n;
          dv_q   <= {dv_q[NW-2:0], 1'b0};
        end
        dv_cnt <= dv_cnt + DCW'(1);
        if (dv_cnt == DCW'(NW - 1)) begin
          dv_busy  <= 1'b0;
          div_done <= 1'b1;
        end
      end

      if (cmd.mul_start) mul_op_r <= cmd.mul_op;

      if (mul_done) begin
        case (mul_op_r)
          MUL_W:   w <= mul_val;
          MUL_G:   g <= mul_val;
          MUL_T:   t <= mul_val;
          MUL_P:   p <= mul_val;
          default: q <= mul_val;
        endcase
        if (mul_clip) clip <= 1'b1;
      end

      if (cmd.acc) begin
        acc[cmd.sel] <= asum_c[ACC_W-1:0];
        if (acc_clip) clip <= 1'b1;
      end

      if (cmd.sat) begin
        dlt[cmd.sel] <= sat_val;
        if (sat_clip) clip <= 1'b1;
      end

      if (out_ch.valid && out_ch.ready) out_full <= 1'b0;

      if (cmd.out_load) begin
        out_full <= 1'b1;
        out_idx  <= held_idx;
        out_d    <= dlt;
        out_sat  <= clip;
        acc      <= '{default: '0};
        clip     <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = cmd.ready;
  assign out_ch.valid        = out_full;
  assign out_ch.result_index = out_idx;
  assign out_ch.delta_x      = out_d[0];
  assign out_ch.delta_y      = out_d[1];
  assign out_ch.delta_z      = out_d[2];
  assign out_ch.saturated    = out_sat;

  assign stat.in_valid  = in_ch.valid;
  assign stat.op        = in_op;
  assign stat.last      = in_last;
  assign stat.skip      = far || (sumsq == 64'd0) || (sumsq >= {2'b00, hh});
  assign stat.root_done = root_done;
  assign stat.mul_done  = mul_done;
  assign stat.div_done  = div_done;
  assign stat.out_full  = out_full;

endmodule
`default_nettype wire

/* hdl/fdpc_ctrl.sv */
// Controller: sequences one request through the datapath.
`default_nettype none
module fdpc_ctrl import fdpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_DIFF, S_SQ, S_CHK, S_ROOT_GO, S_ROOT_WAIT, S_DD,
    S_W_GO, S_W_WAIT, S_DIV_GO, S_DIV_WAIT, S_G_GO, S_G_WAIT, S_T_GO, S_T_WAIT,
    S_ACC, S_FINISH, S_P_GO, S_P_WAIT, S_Q_GO, S_Q_WAIT, S_SAT, S_LOAD
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] sel;
  logic [1:0] sel_next;
  logic       ready;

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_W;
    cmd.ready  = ready;
    cmd.sel    = sel;
    state_next = state;
    sel_next   = sel;
    unique case (state)
      S_IDLE: begin
        cmd.take = stat.in_valid && ready;
        if (cmd.take) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.op) begin
          cmd.begin_grp = 1'b1;
          sel_next      = 2'd0;
          state_next    = stat.last ? S_P_GO : S_IDLE;
        end else begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        sel_next   = 2'd0;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq   = 1'b1;
        sel_next = sel + 2'd1;
        if (sel == 2'd2) state_next = S_CHK;
      end
      S_CHK: state_next = stat.skip ? S_FINISH : S_ROOT_GO;
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_next     = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: if (stat.root_done) state_next = S_DD;
      S_DD: begin
        cmd.dd     = 1'b1;
        state_next = S_W_GO;
      end
      S_W_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = MUL_W;
        state_next    = S_W_WAIT;
      end
      S_W_WAIT: begin
        if (stat.mul_done) begin
          sel_next   = 2'd0;
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (stat.div_done) state_next = S_G_GO;
      S_G_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = MUL_G;
        state_next    = S_G_WAIT;
      end
      S_G_WAIT: if (stat.mul_done) state_next = S_T_GO;
      S_T_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = MUL_T;
        state_next    = S_T_WAIT;
      end
      S_T_WAIT: if (stat.mul_done) state_next = S_ACC;
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sel == 2'd2) begin
          state_next = S_FINISH;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = S_DIV_GO;
        end
      end
      S_FINISH: begin
        sel_next   = 2'd0;
        state_next = stat.last ? S_P_GO : S_IDLE;
      end
      S_P_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = MUL_P;
        state_next    = S_P_WAIT;
      end
      S_P_WAIT: if (stat.mul_done) state_next = S_Q_GO;
      S_Q_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = MUL_Q;
        state_next    = S_Q_WAIT;
      end
      S_Q_WAIT: if (stat.mul_done) state_next = S_SAT;
      S_SAT: begin
        cmd.sat = 1'b1;
        if (sel == 2'd2) begin
          state_next = S_LOAD;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = S_P_GO;
        end
      end
      S_LOAD: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= '0;
      ready <= 1'b1;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      ready <= (state_next == S_IDLE);
    end
  end

endmodule
`default_nettype wire
